[sv/ctd_pkg.sv]
`default_nettype none

package ctd_pkg;

  localparam int DATA_W = 8;
  localparam int MAX_BODY_W = 32;
  localparam int TRAILER_W = 14;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int KIND_W = 2;

  localparam logic [MAX_BODY_W-1:0] MAX_BODY_RESET = 32'd1048576;
  localparam logic [TRAILER_W-1:0] MAX_TRAILER_RESET = 14'd8192;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_BODY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_TRAILER = 2'd1;

  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MALFORMED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TOO_LARGE = 2'd3;

  localparam logic [DATA_W-1:0] CH_LF = 8'h0A;
  localparam logic [DATA_W-1:0] CH_CR = 8'h0D;
  localparam logic [DATA_W-1:0] CH_TAB = 8'h09;
  localparam logic [DATA_W-1:0] CH_VT = 8'h0B;
  localparam logic [DATA_W-1:0] CH_FF = 8'h0C;
  localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [DATA_W-1:0] b);
    hex_digit_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.value = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.value = 4'(b - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_blank(input logic [DATA_W-1:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF || b == CH_CR;
  endfunction

endpackage

`default_nettype wire

[sv/chunked_transfer_decoder.sv]
// Chunked body decoder. Raw body bytes enter on the s_ channel, one per beat,
// with s_tuser[0] set on the first byte of a new body, which clears all
// decoding state before that byte is parsed. Decoded payload bytes and status
// beats leave on the m_ channel: m_tuser gives the kind (payload, body
// complete, malformed, too large) and m_tdata the payload byte, zero otherwise.
// Size lines, chunk CR LF and trailer lines produce no output beat.
// The two limits are written on the cfg_ channel (index 0 largest body,
// index 1 longest trailer line); the user must write them only while the
// decoder is idle, as the block does not enforce it. cfg_ready is always high.
// An accepted byte sits in the input register and is parsed into the result
// register at an edge where the result register is empty or being taken.
// One byte per cycle is sustained while m_tready is high; the single parse
// step per byte sets that rate. When the receiver stalls, the result register
// holds its beat and the input register holds one more byte, after which
// s_tready drops. Errors are sticky until a new body starts.
// Reset empties both registers, restores the limits to 1048576 and 8192
// bytes and returns the parser to the start of a size line.
`default_nettype none

module chunked_transfer_decoder #(
  parameter int SIZE_LINE_MAX = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [ctd_pkg::DATA_W-1:0]      s_tdata,   // data_byte
  input  wire logic                            s_tuser,   // new_body
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [ctd_pkg::DATA_W-1:0]           m_tdata,   // out_byte
  output logic [ctd_pkg::KIND_W-1:0]           m_tuser,   // kind
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ctd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ctd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CMP_W = (COUNT_WIDTH > ctd_pkg::MAX_BODY_W) ? COUNT_WIDTH
                                                             : ctd_pkg::MAX_BODY_W;
  localparam int LEN_W = ctd_pkg::TRAILER_W;

  typedef enum logic [3:0] {
    PH_SIZE_LEAD,
    PH_SIZE_NUM,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF,
    PH_TR_START,
    PH_TR_CR,
    PH_TR_LINE,
    PH_DONE,
    PH_ERROR
  } phase_t;

  logic [ctd_pkg::MAX_BODY_W-1:0] max_body_bytes;
  logic [ctd_pkg::TRAILER_W-1:0]  max_trailer_line;

  logic                       in_valid;
  logic [ctd_pkg::DATA_W-1:0] in_byte;
  logic                       in_new_body;

  phase_t                         phase, phase_next;
  logic [COUNT_WIDTH-1:0]         remaining_count, remaining_count_next;
  logic [COUNT_WIDTH-1:0]         size_accum, size_accum_next;
  logic                           number_ended, number_ended_next;
  logic [LEN_W-1:0]               line_length, line_length_next;
  logic [ctd_pkg::MAX_BODY_W-1:0] body_total, body_total_next;

  logic                       res_valid;
  logic [ctd_pkg::KIND_W-1:0] res_kind;
  logic [ctd_pkg::DATA_W-1:0] res_byte;

  logic advance;

  phase_t                         cur_phase;
  logic [COUNT_WIDTH-1:0]         cur_remaining;
  logic [COUNT_WIDTH-1:0]         cur_accum;
  logic                           cur_ended;
  logic [LEN_W-1:0]               cur_length;
  logic [ctd_pkg::MAX_BODY_W-1:0] cur_total;

  ctd_pkg::hex_digit_t            hex;
  logic [COUNT_WIDTH-1:0]         accum_added;
  logic [ctd_pkg::MAX_BODY_W-1:0] room;
  logic                           too_large;
  logic [LEN_W:0]                 trailer_len;
  logic                           trailer_over;
  logic [COUNT_WIDTH-1:0]         remaining_dec;

  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (in_new_body) begin
      cur_phase     = PH_SIZE_LEAD;
      cur_remaining = '0;
      cur_accum     = '0;
      cur_ended     = 1'b0;
      cur_length    = '0;
      cur_total     = '0;
    end else begin
      cur_phase     = phase;
      cur_remaining = remaining_count;
      cur_accum     = size_accum;
      cur_ended     = number_ended;
      cur_length    = line_length;
      cur_total     = body_total;
    end
  end

  always_comb begin
    hex = ctd_pkg::hex_decode(in_byte);
    if (|cur_accum[COUNT_WIDTH-1 -: 4]) begin
      accum_added = '1;
    end else begin
      accum_added = {cur_accum[COUNT_WIDTH-5:0], hex.value};
    end
    room = (cur_total <= max_body_bytes) ? max_body_bytes - cur_total : '0;
    too_large = CMP_W'(cur_accum) > CMP_W'(room);
    trailer_len = {1'b0, cur_length} + (LEN_W+1)'(1);
    trailer_over = trailer_len > (LEN_W+1)'(max_trailer_line);
    remaining_dec = cur_remaining - COUNT_WIDTH'(1);
  end

  always_comb begin
    phase_next           = cur_phase;
    remaining_count_next = cur_remaining;
    size_accum_next      = cur_accum;
    number_ended_next    = cur_ended;
    line_length_next     = cur_length;
    body_total_next      = cur_total;
    res_valid            = 1'b0;
    res_kind             = ctd_pkg::KIND_PAYLOAD;
    res_byte             = '0;
    unique case (cur_phase)
      PH_SIZE_LEAD, PH_SIZE_NUM: begin
        if (cur_length >= LEN_W'(SIZE_LINE_MAX - 1)) begin
          phase_next = PH_ERROR;
          res_valid  = 1'b1;
          res_kind   = ctd_pkg::KIND_MALFORMED;
        end else if (in_byte == ctd_pkg::CH_LF) begin
          size_accum_next   = '0;
          number_ended_next = 1'b0;
          line_length_next  = '0;
          if (too_large) begin
            phase_next = PH_ERROR;
            res_valid  = 1'b1;
            res_kind   = ctd_pkg::KIND_TOO_LARGE;
          end else if (cur_accum == '0) begin
            phase_next = PH_TR_START;
          end else begin
            remaining_count_next = cur_accum;
            phase_next           = PH_DATA;
          end
        end else begin
          line_length_next = cur_length + LEN_W'(1);
          if (cur_phase == PH_SIZE_LEAD) begin
            if (!ctd_pkg::is_blank(in_byte)) begin
              phase_next = PH_SIZE_NUM;
              if (hex.valid) begin
                size_accum_next = accum_added;
              end else begin
                number_ended_next = 1'b1;
              end
            end
          end else if (!cur_ended && hex.valid) begin
            size_accum_next = accum_added;
          end else begin
            number_ended_next = 1'b1;
          end
        end
      end
      PH_DATA: begin
        body_total_next      = cur_total + ctd_pkg::MAX_BODY_W'(1);
        remaining_count_next = remaining_dec;
        if (remaining_dec == '0) begin
          phase_next = PH_DATA_CR;
        end
        res_valid = 1'b1;
        res_byte  = in_byte;
      end
      PH_DATA_CR: begin
        if (in_byte != ctd_pkg::CH_CR) begin
          phase_next = PH_ERROR;
          res_valid  = 1'b1;
          res_kind   = ctd_pkg::KIND_MALFORMED;
        end else begin
          phase_next = PH_DATA_LF;
        end
      end
      PH_DATA_LF: begin
        if (in_byte != ctd_pkg::CH_LF) begin
          phase_next = PH_ERROR;
          res_valid  = 1'b1;
          res_kind   = ctd_pkg::KIND_MALFORMED;
        end else begin
          phase_next       = PH_SIZE_LEAD;
          line_length_next = '0;
        end
      end
      PH_TR_START, PH_TR_CR, PH_TR_LINE: begin
        if (in_byte == ctd_pkg::CH_LF) begin
          line_length_next = '0;
          if (cur_phase == PH_TR_CR) begin
            phase_next = PH_DONE;
            res_valid  = 1'b1;
            res_kind   = ctd_pkg::KIND_DONE;
          end else begin
            phase_next = PH_TR_START;
          end
        end else if (trailer_over) begin
          phase_next = PH_ERROR;
          res_valid  = 1'b1;
          res_kind   = ctd_pkg::KIND_MALFORMED;
        end else begin
          line_length_next = trailer_len[LEN_W-1:0];
          if (cur_phase == PH_TR_START && in_byte == ctd_pkg::CH_CR) begin
            phase_next = PH_TR_CR;
          end else begin
            phase_next = PH_TR_LINE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_bytes   <= ctd_pkg::MAX_BODY_RESET;
      max_trailer_line <= ctd_pkg::MAX_TRAILER_RESET;
      in_valid         <= 1'b0;
      m_tvalid         <= 1'b0;
      phase            <= PH_SIZE_LEAD;
      remaining_count  <= '0;
      size_accum       <= '0;
      number_ended     <= 1'b0;
      line_length      <= '0;
      body_total       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ctd_pkg::REG_MAX_BODY) begin
          max_body_bytes <= cfg_data;
        end else if (cfg_index == ctd_pkg::REG_MAX_TRAILER) begin
          max_trailer_line <= cfg_data[ctd_pkg::TRAILER_W-1:0];
        end
      end
      if (s_tvalid && s_tready) begin
        in_valid    <= 1'b1;
        in_byte     <= s_tdata;
        in_new_body <= s_tuser;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        phase           <= phase_next;
        remaining_count <= remaining_count_next;
        size_accum      <= size_accum_next;
        number_ended    <= number_ended_next;
        line_length     <= line_length_next;
        body_total      <= body_total_next;
      end
      if (advance && res_valid) begin
        m_tvalid <= 1'b1;
        m_tdata  <= res_byte;
        m_tuser  <= res_kind;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[sv/ctd_checker.sv]
`default_nettype none

module ctd_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_tready,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [ctd_pkg::DATA_W-1:0]  m_tdata,
  input wire logic [ctd_pkg::KIND_W-1:0]  m_tuser
);

  // A status beat never carries a payload byte.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ctd_pkg::KIND_PAYLOAD |-> m_tdata == '0)
    else $error("status beat with nonzero data");

  // With the result register empty the input side must be open.
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked while output is empty");

  // Reset empties the output register.
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output beat valid right after reset");

  // A stalled output beat holds.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output beat changed");

endmodule

bind chunked_transfer_decoder ctd_checker u_ctd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
